[sv/epas_pkg.sv]
// shared types and constants for the encoder period average speed unit
package epas_pkg;

    // width of the shared divider datapath (speed numerator plus aligned divisor)
    localparam int DIV_W = 68;
    // step counter width of the divider, counts up to 32 steps
    localparam int STEP_W = 6;
    // quotient register width
    localparam int QUOT_W = 32;

    // average division: 32 quotient bits, divisor aligned by 31
    localparam logic [STEP_W-1:0] AVG_STEPS = STEP_W'(32);
    localparam int AVG_ALIGN = 31;
    // speed division: 25 quotient bits, bit 24 set means saturate
    localparam logic [STEP_W-1:0] SPD_STEPS = STEP_W'(25);
    localparam int SPD_ALIGN = 24;

    // speed numerator is 65536e6 + 2^18 * D, divisor 5 * D
    localparam logic [DIV_W-1:0] NUM_BIAS = DIV_W'(64'd65536000000);
    localparam int NUM_SHIFT = 18;
    localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;

    localparam logic [15:0] US_PER_TICK_RST = 16'd250;
    localparam logic [7:0] STEPS_PER_REV_RST = 8'd30;

    // configuration register indexes
    localparam logic CFG_US_PER_TICK = 1'b0;
    localparam logic CFG_STEPS_PER_REV = 1'b1;

    // event kinds
    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_OVERFLOW = 1'b1;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    // answer from the shared divider
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

[sv/epas_ram.sv]
// generic single-write, single-read ram with registered read data
module epas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/epas_div.sv]
// shared restoring divider, one quotient bit per cycle against a pre-aligned divisor
module epas_div
    import epas_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ge;

    assign ge = (rem_reg >= dvs_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            dvs_next  = req.divisor;
            quot_next = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dvs_reg;
            end
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            dvs_next  = dvs_reg >> 1;
            cnt_next  = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[sv/encoder_period_average_speed_unit.sv]
// top level: encoder pulse width moving average and speed ratio
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata = ticks[15:0], tuser = func
// m_*       out  tvalid/tready      tdata = mean_width[31:0], speed_ratio[55:32]
//                                   tuser = timed_out
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data = value
//
// a capture runs mul_w, update, div_avg and wait_avg (mean on the shared divider, 32 quotient
// bits), then mul_d, div_spd and wait_spd (speed ratio, 25 quotient bits), then finish;
// a zero D skips the speed division; a capture that only clears the timeout skips the
// mean and the window update; an overflow event goes straight from idle to finish
// s_tready is high only while the sequencer is idle; finish holds while the output register
// is full and m_tready is low, otherwise the next transaction is taken while the result waits
// reset clears the sequencer, fill count, sum, average and flag; the window ram is not cleared
module encoder_period_average_speed_unit
    import epas_pkg::*;
#(
    parameter int WINDOW_LEN = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // ticks[15:0]
    input  logic        s_tuser,   // func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // mean_width[31:0], speed_ratio[55:32]
    output logic        m_tuser,   // timed_out
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = 32 + CNT_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MUL_W    = 9'b000000010,
        ST_UPDATE   = 9'b000000100,
        ST_DIV_AVG  = 9'b000001000,
        ST_WAIT_AVG = 9'b000010000,
        ST_MUL_D    = 9'b000100000,
        ST_DIV_SPD  = 9'b001000000,
        ST_WAIT_SPD = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] us_reg;
    logic [7:0]  steps_reg;

    // window bookkeeping
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [31:0]       avg_reg, avg_next;
    logic              timeout_reg, timeout_next;
    logic              full;

    // per transaction payload
    logic [15:0] ticks_reg;
    logic [31:0] width_reg;
    logic [31:0] old_reg;
    logic [39:0] d_reg;
    logic [23:0] spd_reg, spd_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_mean_reg;
    logic [23:0] m_spd_reg;
    logic        m_to_reg;
    logic        load_out;

    // ram and divider
    logic [31:0] ram_rd_data;
    logic        ram_we;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic [DIV_W-1:0] d_ext;

    logic accept;

    assign full     = (fill_reg == CNT_W'(WINDOW_LEN));
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    assign ram_we   = (state_reg == ST_UPDATE);
    assign d_ext    = DIV_W'(d_reg);

    epas_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (slot_reg),
        .wr_data (width_reg),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    epas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // divider request: mean division or speed division
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(sum_reg);
        div_req.divisor  = DIV_W'(fill_reg) << AVG_ALIGN;
        div_req.steps    = AVG_STEPS;
        case (state_reg)
            ST_DIV_AVG:
            begin
                div_req.start = 1'b1;
            end
            ST_DIV_SPD:
            begin
                // zero D covers a zero mean and zero steps per revolution
                div_req.start    = (d_reg != '0);
                div_req.dividend = (d_ext << NUM_SHIFT) + NUM_BIAS;
                div_req.divisor  = ((d_ext << 2) + d_ext) << SPD_ALIGN;
                div_req.steps    = SPD_STEPS;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        timeout_next = timeout_reg;
        spd_next     = spd_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_OVERFLOW)
                    begin
                        timeout_next = 1'b1;
                        spd_next     = '0;
                        state_next   = ST_FINISH;
                    end
                    else if (timeout_reg)
                    begin
                        // capture after timeout clears the flag and skips the window update
                        timeout_next = 1'b0;
                        state_next   = ST_MUL_D;
                    end
                    else
                    begin
                        state_next = ST_MUL_W;
                    end
                end
            end
            ST_MUL_W:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(width_reg);
                if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                if (!full)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                state_next = ST_DIV_AVG;
            end
            ST_DIV_AVG:
            begin
                state_next = ST_WAIT_AVG;
            end
            ST_WAIT_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quot;
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                state_next = ST_DIV_SPD;
            end
            ST_DIV_SPD:
            begin
                if (d_reg == '0)
                begin
                    spd_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WAIT_SPD;
                end
            end
            ST_WAIT_SPD:
            begin
                if (div_rsp.done)
                begin
                    // quotient bit 24 set means the ratio exceeds Q8.16 range
                    spd_next   = div_rsp.quot[SPD_ALIGN] ? SPEED_MAX : div_rsp.quot[23:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            avg_reg     <= '0;
            timeout_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            us_reg      <= US_PER_TICK_RST;
            steps_reg   <= STEPS_PER_REV_RST;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            avg_reg     <= avg_next;
            timeout_reg <= timeout_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_US_PER_TICK:   us_reg    <= cfg_data;
                    CFG_STEPS_PER_REV: steps_reg <= cfg_data[7:0];
                    default:           us_reg    <= us_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        spd_reg <= spd_next;
        if (accept)
        begin
            ticks_reg <= s_tdata;
        end
        if (state_reg == ST_MUL_W)
        begin
            width_reg <= {16'b0, ticks_reg} * {16'b0, us_reg};
            // oldest entry leaves the sum only once the window is full
            old_reg   <= full ? ram_rd_data : '0;
        end
        if (state_reg == ST_MUL_D)
        begin
            d_reg <= {32'b0, steps_reg} * {8'b0, avg_reg};
        end
        if (load_out)
        begin
            m_mean_reg <= avg_reg;
            m_spd_reg  <= spd_reg;
            m_to_reg   <= timeout_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_spd_reg, m_mean_reg};
    assign m_tuser  = m_to_reg;

endmodule

[test/tb.sv]
// testbench for the encoder period average speed unit, scoreboard class and stream drivers
`timescale 1ns / 1ps

import epas_pkg::*;

typedef struct packed {
    logic [31:0] mean_width;
    logic [23:0] speed_ratio;
    logic        timed_out;
} speed_result_t;

// tracks the moving average and predicts one result per event
class speed_scoreboard;
    localparam int SPAN = 30;

    logic [31:0]   widths [SPAN];
    logic [4:0]    fill_slot;
    bit            full;
    logic [36:0]   window_total;
    logic [31:0]   mean;
    bit            timeout;
    logic [15:0]   us_per_tick;
    logic [7:0]    steps_per_rev;
    speed_result_t expected_results [$];
    int            mismatches;

    function new();
        us_per_tick   = US_PER_TICK_RST;
        steps_per_rev = STEPS_PER_REV_RST;
        fill_slot     = '0;
        full          = 1'b0;
        window_total  = '0;
        mean          = '0;
        timeout       = 1'b0;
        mismatches    = 0;
    endfunction

    function void write_register(logic index, logic [15:0] value);
        if (index == CFG_US_PER_TICK)
            us_per_tick = value;
        else
            steps_per_rev = value[7:0];
    endfunction

    // q8.16 of 0.2e6 / (steps * mean) + 0.8, saturated
    function logic [23:0] speed_ratio();
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        if (timeout || mean == 32'd0)
            return 24'd0;
        d = 64'(steps_per_rev) * 64'(mean);
        if (d == 64'd0)
            return 24'd0;
        num = 64'd65536000000 + (d << 18);
        q = num / (64'd5 * d);
        if (q > 64'(SPEED_MAX))
            q = 64'(SPEED_MAX);
        return q[23:0];
    endfunction

    function void push_width(logic [31:0] w);
        int fill;
        if (full)
        begin
            window_total = window_total - 37'(widths[fill_slot]) + 37'(w);
            widths[fill_slot] = w;
            mean = 32'(window_total / SPAN);
            fill_slot = (int'(fill_slot) == SPAN - 1) ? 5'd0 : 5'(fill_slot + 5'd1);
        end
        else
        begin
            widths[fill_slot] = w;
            window_total = window_total + 37'(w);
            fill = int'(fill_slot) + 1;
            mean = 32'(window_total / 37'(fill));
            if (fill >= SPAN)
            begin
                full = 1'b1;
                fill_slot = 5'd0;
            end
            else
                fill_slot = 5'(fill);
        end
    endfunction

    function void predict_event(logic func, logic [15:0] ticks);
        speed_result_t r;
        if (func == FUNC_OVERFLOW)
            timeout = 1'b1;
        else if (timeout)
            timeout = 1'b0;   // capture only clears the flag
        else
            push_width(32'(ticks) * 32'(us_per_tick));
        r.mean_width  = mean;
        r.speed_ratio = speed_ratio();
        r.timed_out   = timeout;
        expected_results.push_back(r);
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch in %s: got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task check_result(logic [55:0] data, logic flag);
        speed_result_t want;
        if (expected_results.size() == 0)
        begin
            report("result with nothing outstanding", data[31:0], 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (data[31:0] != want.mean_width)
            report("mean_width", data[31:0], want.mean_width);
        if (data[55:32] != want.speed_ratio)
            report("speed_ratio", 32'(data[55:32]), 32'(want.speed_ratio));
        if (flag != want.timed_out)
            report("timed_out", 32'(flag), 32'(want.timed_out));
    endtask
endclass

module tb;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // ticks[15:0]
    logic        s_tuser   = FUNC_CAPTURE;   // func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // mean_width[31:0], speed_ratio[55:32]
    logic        m_tuser;          // timed_out
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_US_PER_TICK;
    logic [15:0] cfg_data  = '0;

    speed_scoreboard sb = new();

    // both sides run without gaps while set
    bit quiet = 1'b0;
    int stall_left = 0;

    encoder_period_average_speed_unit #(
        .WINDOW_LEN(30)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // mostly no gap, some short ones, a few long enough to cover a whole event
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // small counts, full range, extremes, or jitter around a steady width; narrow gives only small counts
    function automatic logic [15:0] pick_ticks(logic [15:0] base, bit narrow);
        int r;
        r = $urandom_range(0, 9);
        if (narrow && r != 0)
            return 16'($urandom_range(0, 40));
        case (r)
            0, 1, 2: return 16'($urandom_range(0, 15));
            3, 4, 5: return 16'($urandom_range(0, 65535));
            6:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return base + 16'($urandom_range(0, 63)) - 16'd32;
        endcase
    endfunction

    // result side: check every transaction, stall m_tready at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left = idle_cycles();
            m_tready <= (stall_left == 0);
        end
    end

    // hold the event until the block takes it, then predict its result
    task automatic send_event(input logic func, input logic [15:0] ticks);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= ticks;
        do
            @(posedge clk);
        while (!s_tready);
        sb.predict_event(func, ticks);
    endtask

    task automatic pause_sender();
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.write_register(index, value);
    endtask

    task automatic run_phase(input logic [15:0] us, input logic [7:0] steps,
                             input int count, input bit narrow);
        logic [15:0] base;
        logic        func;
        drain();
        write_register(CFG_US_PER_TICK, us);
        write_register(CFG_STEPS_PER_REV, 16'(steps));
        base = 16'($urandom_range(0, 65535));
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            // sender holds off until the block has answered everything
            if (i == count / 2)
                drain();
            if ($urandom_range(0, 49) == 0)
                base = 16'($urandom_range(0, 65535));
            func = ($urandom_range(0, 99) < 8) ? FUNC_OVERFLOW : FUNC_CAPTURE;
            send_event(func, pick_ticks(base, narrow));
            pause_sender();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: zero mean, full-scale capture, timeout handling
        send_event(FUNC_CAPTURE, 16'h0000);
        send_event(FUNC_CAPTURE, 16'hFFFF);
        send_event(FUNC_OVERFLOW, 16'hFFFF);
        send_event(FUNC_OVERFLOW, 16'h0000);
        send_event(FUNC_CAPTURE, 16'd1234);     // only clears the flag
        send_event(FUNC_CAPTURE, 16'd1);
        send_event(FUNC_CAPTURE, 16'h5555);
        send_event(FUNC_CAPTURE, 16'hAAAA);
        send_event(FUNC_OVERFLOW, 16'd7);
        send_event(FUNC_CAPTURE, 16'h0000);
        // zero scale makes every width zero
        drain();
        write_register(CFG_US_PER_TICK, 16'd0);
        send_event(FUNC_CAPTURE, 16'd500);
        send_event(FUNC_CAPTURE, 16'hFFFF);
        // largest width the product can reach
        drain();
        write_register(CFG_US_PER_TICK, 16'hFFFF);
        write_register(CFG_STEPS_PER_REV, 16'd255);
        send_event(FUNC_CAPTURE, 16'hFFFF);
        send_event(FUNC_CAPTURE, 16'hFFFF);
        // zero steps per revolution gives a zero ratio
        drain();
        write_register(CFG_STEPS_PER_REV, 16'd0);
        send_event(FUNC_CAPTURE, 16'd100);
        send_event(FUNC_OVERFLOW, 16'd0);
        send_event(FUNC_CAPTURE, 16'd1);
        drain();
        write_register(CFG_US_PER_TICK, 16'd1);
        write_register(CFG_STEPS_PER_REV, 16'd1);
        send_event(FUNC_CAPTURE, 16'd1);
        send_event(FUNC_CAPTURE, 16'd1);
        send_event(FUNC_CAPTURE, 16'd1);

        // random phases over several register settings
        run_phase(16'd250, 8'd30, 186, 1'b0);
        run_phase(16'd1, 8'd1, 186, 1'b1);       // deep in saturation
        run_phase(16'hFFFF, 8'd255, 186, 1'b0);
        run_phase(16'd0, 8'd30, 186, 1'b0);
        run_phase(16'd1000, 8'd0, 186, 1'b0);
        run_phase(16'd1, 8'd40, 186, 1'b1);      // around the saturation edge
        run_phase(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)), 186, 1'b0);
        run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 186, 1'b0);

        drain();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #30000000;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/epas_pkg.sv
sv/epas_ram.sv
sv/epas_div.sv
sv/encoder_period_average_speed_unit.sv
test/tb.sv
